FILE: src/cpualu_pkg.sv
// Shared operation codes, flag bit positions and payload types for the CPU ALU.
`timescale 1ns / 1ps
package cpualu_pkg;

	localparam logic [4:0] OP_ADD   = 5'd0;
	localparam logic [4:0] OP_ADC   = 5'd1;
	localparam logic [4:0] OP_SUB   = 5'd2;
	localparam logic [4:0] OP_SBC   = 5'd3;
	localparam logic [4:0] OP_AND   = 5'd4;
	localparam logic [4:0] OP_OR    = 5'd5;
	localparam logic [4:0] OP_XOR   = 5'd6;
	localparam logic [4:0] OP_CP    = 5'd7;
	localparam logic [4:0] OP_INC   = 5'd8;
	localparam logic [4:0] OP_DEC   = 5'd9;
	localparam logic [4:0] OP_NEG   = 5'd10;
	localparam logic [4:0] OP_RLC   = 5'd11;
	localparam logic [4:0] OP_RRC   = 5'd12;
	localparam logic [4:0] OP_RL    = 5'd13;
	localparam logic [4:0] OP_RR    = 5'd14;
	localparam logic [4:0] OP_SLA   = 5'd15;
	localparam logic [4:0] OP_SRA   = 5'd16;
	localparam logic [4:0] OP_SRL   = 5'd17;
	localparam logic [4:0] OP_ADD16 = 5'd18;
	localparam logic [4:0] OP_ADC16 = 5'd19;
	localparam logic [4:0] OP_SBC16 = 5'd20;
	localparam logic [4:0] OP_INC16 = 5'd21;
	localparam logic [4:0] OP_DEC16 = 5'd22;

	localparam int FL_S  = 7;
	localparam int FL_Z  = 6;
	localparam int FL_Y  = 5;
	localparam int FL_H  = 4;
	localparam int FL_X  = 3;
	localparam int FL_PV = 2;
	localparam int FL_N  = 1;
	localparam int FL_C  = 0;

	typedef struct packed {
		logic [4:0]  operation;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [7:0]  flags_in;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] result;
		logic [7:0]  flags_out;
	} alu_rsp_t;

endpackage

FILE: src/cpualu_if.sv
// Valid/ready channel interfaces for ALU commands and responses.
`timescale 1ns / 1ps
interface cpualu_cmd_if;
	logic        valid;
	logic        ready;
	logic [4:0]  operation;
	logic [15:0] operand_a;
	logic [15:0] operand_b;
	logic [7:0]  flags_in;

	modport source (output valid, operation, operand_a, operand_b, flags_in, input ready);
	modport sink (input valid, operation, operand_a, operand_b, flags_in, output ready);
endinterface

interface cpualu_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] result;
	logic [7:0]  flags_out;

	modport source (output valid, result, flags_out, input ready);
	modport sink (input valid, result, flags_out, output ready);
endinterface

FILE: src/cpualu_core.sv
// Combinational 8/16-bit ALU datapath with flag generation.
`timescale 1ns / 1ps
module cpualu_core
	import cpualu_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] f;
	} arith8_t;

	typedef struct packed {
		logic [15:0] r;
		logic [7:0]  f;
	} arith16_t;

	function automatic arith8_t arith8(input logic [7:0] a, input logic [7:0] b,
			input logic cin, input logic sub);
		logic [8:0] s9;
		logic [4:0] h5;
		logic       ov;
		arith8_t    o;
		if (sub) begin
			s9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
			h5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
			ov = (a[7] ^ b[7]) & (a[7] ^ s9[7]);
		end else begin
			s9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
			h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
			ov = ~(a[7] ^ b[7]) & (a[7] ^ s9[7]);
		end
		o.r        = s9[7:0];
		o.f        = 8'd0;
		o.f[FL_S]  = s9[7];
		o.f[FL_Z]  = (s9[7:0] == 8'd0);
		o.f[FL_H]  = h5[4];
		o.f[FL_PV] = ov;
		o.f[FL_N]  = sub;
		o.f[FL_C]  = s9[8];
		return o;
	endfunction

	function automatic arith16_t arith16(input logic [15:0] a, input logic [15:0] b,
			input logic cin, input logic sub);
		logic [16:0] s17;
		logic [12:0] h13;
		logic        ov;
		arith16_t    o;
		if (sub) begin
			s17 = {1'b0, a} - {1'b0, b} - {16'd0, cin};
			h13 = {1'b0, a[11:0]} - {1'b0, b[11:0]} - {12'd0, cin};
			ov  = (a[15] ^ b[15]) & (a[15] ^ s17[15]);
		end else begin
			s17 = {1'b0, a} + {1'b0, b} + {16'd0, cin};
			h13 = {1'b0, a[11:0]} + {1'b0, b[11:0]} + {12'd0, cin};
			ov  = ~(a[15] ^ b[15]) & (a[15] ^ s17[15]);
		end
		o.r        = s17[15:0];
		o.f        = 8'd0;
		o.f[FL_S]  = s17[15];
		o.f[FL_Z]  = (s17[15:0] == 16'd0);
		o.f[FL_H]  = h13[12];
		o.f[FL_PV] = ov;
		o.f[FL_N]  = sub;
		o.f[FL_C]  = s17[16];
		return o;
	endfunction

	logic [7:0]  a8;
	logic [7:0]  b8;
	logic        cy;
	logic [7:0]  fin;
	logic [7:0]  lg;
	logic [7:0]  sh;
	logic        cout;
	arith8_t     ar8;
	arith16_t    ar16;
	logic [15:0] r;
	logic [7:0]  f;

	assign a8  = req.operand_a[7:0];
	assign b8  = req.operand_b[7:0];
	assign fin = req.flags_in;
	assign cy  = fin[FL_C];

	// One shared adder per width; operation picks operands, carry-in and direction.
	always_comb begin
		ar8 = arith8(a8, b8, 1'b0, 1'b0);
		case (req.operation)
			OP_ADC:                 ar8 = arith8(a8, b8, cy, 1'b0);
			OP_SUB, OP_CP:          ar8 = arith8(a8, b8, 1'b0, 1'b1);
			OP_SBC:                 ar8 = arith8(a8, b8, cy, 1'b1);
			OP_INC:                 ar8 = arith8(a8, 8'd1, 1'b0, 1'b0);
			OP_DEC:                 ar8 = arith8(a8, 8'd1, 1'b0, 1'b1);
			OP_NEG:                 ar8 = arith8(8'd0, a8, 1'b0, 1'b1);
			default:                ar8 = arith8(a8, b8, 1'b0, 1'b0);
		endcase
	end

	always_comb begin
		case (req.operation)
			OP_ADC16: ar16 = arith16(req.operand_a, req.operand_b, cy, 1'b0);
			OP_SBC16: ar16 = arith16(req.operand_a, req.operand_b, cy, 1'b1);
			OP_INC16: ar16 = arith16(req.operand_a, 16'd1, 1'b0, 1'b0);
			OP_DEC16: ar16 = arith16(req.operand_a, 16'd1, 1'b0, 1'b1);
			default:  ar16 = arith16(req.operand_a, req.operand_b, 1'b0, 1'b0);
		endcase
	end

	always_comb begin
		case (req.operation)
			OP_AND:  lg = a8 & b8;
			OP_OR:   lg = a8 | b8;
			default: lg = a8 ^ b8;
		endcase
	end

	always_comb begin
		case (req.operation)
			OP_RLC:  begin sh = {a8[6:0], a8[7]}; cout = a8[7]; end
			OP_RRC:  begin sh = {a8[0], a8[7:1]}; cout = a8[0]; end
			OP_RL:   begin sh = {a8[6:0], cy};    cout = a8[7]; end
			OP_RR:   begin sh = {cy, a8[7:1]};    cout = a8[0]; end
			OP_SLA:  begin sh = {a8[6:0], 1'b0};  cout = a8[7]; end
			OP_SRA:  begin sh = {a8[7], a8[7:1]}; cout = a8[0]; end
			default: begin sh = {1'b0, a8[7:1]};  cout = a8[0]; end
		endcase
	end

	always_comb begin
		r = req.operand_a;
		f = fin;
		case (req.operation)
			OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_NEG: begin
				r = {8'd0, ar8.r};
				f = ar8.f;
			end
			OP_CP: begin
				r = req.operand_a;
				f = ar8.f;
			end
			OP_INC, OP_DEC: begin
				r = {8'd0, ar8.r};
				f = ar8.f;
				f[FL_C] = cy;
			end
			OP_AND, OP_OR, OP_XOR: begin
				r = {8'd0, lg};
				f = 8'd0;
				f[FL_S]  = lg[7];
				f[FL_Z]  = (lg == 8'd0);
				f[FL_H]  = (req.operation == OP_AND);
				f[FL_PV] = ~^lg;
			end
			OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
				r = {8'd0, sh};
				f = 8'd0;
				f[FL_S]  = sh[7];
				f[FL_Z]  = (sh == 8'd0);
				f[FL_PV] = ~^sh;
				f[FL_C]  = cout;
			end
			OP_ADD16: begin
				r = ar16.r;
				f = fin;
				f[FL_H] = ar16.f[FL_H];
				f[FL_N] = 1'b0;
				f[FL_C] = ar16.f[FL_C];
			end
			OP_ADC16, OP_SBC16: begin
				r = ar16.r;
				f = ar16.f;
			end
			OP_INC16, OP_DEC16: begin
				r = ar16.r;
				f = fin;
			end
			default: begin
				r = req.operand_a;
				f = fin;
			end
		endcase
		// Undocumented bits always pass through.
		f[FL_Y] = fin[FL_Y];
		f[FL_X] = fin[FL_X];
	end

	assign rsp.result    = r;
	assign rsp.flags_out = f;

endmodule

FILE: src/cpu_alu_with_flags.sv
// Top level of the 8/16-bit CPU ALU with flag byte, valid/ready command and response channels.
// Path: input register, ALU, result register; the ALU sits between the two registers in a
// single pass. Throughput: one command per cycle while the response channel is not stalled.
// A stalled response only blocks the input register once both stages are full.
// Reset (arst_n low, asynchronous) empties both stages; payload registers are not cleared.
`timescale 1ns / 1ps
module cpu_alu_with_flags
	import cpualu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	cpualu_cmd_if.sink   cmd,
	cpualu_rsp_if.source rsp
);

	logic     valid_s1;
	alu_req_t req_s1;
	logic     ready_s1;
	alu_rsp_t alu_out;
	logic     out_valid_q;
	alu_rsp_t out_q;

	assign ready_s1  = !out_valid_q || rsp.ready;
	assign cmd.ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			req_s1.operation <= cmd.operation;
			req_s1.operand_a <= cmd.operand_a;
			req_s1.operand_b <= cmd.operand_b;
			req_s1.flags_in  <= cmd.flags_in;
		end
	end

	cpualu_core u_core (
		.req (req_s1),
		.rsp (alu_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	// Capture the ALU result whenever stage one advances.
	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			out_q <= alu_out;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.result    = out_q.result;
	assign rsp.flags_out = out_q.flags_out;

`ifndef SYNTHESIS
	a_cmd_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> valid_s1)
		else $error("transfer into stage one lost");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s1 |=> valid_s1 && $stable(req_s1))
		else $error("stage one changed while blocked");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s1 |=> out_valid_q)
		else $error("stage one advanced without a response");

	a_wide_step_keeps_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s1 &&
		(req_s1.operation == OP_INC16 || req_s1.operation == OP_DEC16)
		|=> rsp.flags_out == $past(req_s1.flags_in))
		else $error("16-bit increment or decrement altered flags");
`endif

endmodule
